// File: design/qscdr_pkg.sv
// Package for the quadrature step counter with delta report.
// Holds command and phase codes and the fixed field widths.
// Depends on nothing.
package qscdr_pkg;

  localparam int unsigned POS_W    = 8;
  localparam int unsigned OFFSET_W = 9;

  typedef enum logic {
    CMD_PIN  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef logic [1:0] phase_t;

  localparam phase_t PHASE_00 = 2'd0;
  localparam phase_t PHASE_01 = 2'd1;
  localparam phase_t PHASE_10 = 2'd2;
  localparam phase_t PHASE_11 = 2'd3;

  localparam logic [POS_W-1:0] OFFSET_RESET = 8'd128;

endpackage

// File: design/quadrature_step_counter_delta_report.sv
// Top level of the quadrature step counter with delta report.
// Uses qscdr_pkg for codes and widths.
//
// Input channel (in_valid / in_stall): one transaction carries cmd, phase_a,
// phase_b, report_enable and sink_ready. cmd = pin sample updates the
// wrapping step position from the phase code; cmd = report tick compares the
// position with the last reported one and may emit one report.
// Output channel (out_valid / out_stall): step_delta, offset_delta (delta
// plus the offset register) and position.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes
// delta_offset; always ready, write only while the block is idle.
// A taken tick sits in the input register; its report then loads the result
// register and appears on out_valid. Throughput: one transaction per cycle
// while out_stall does not hold a report, set by the combinational state
// update between the two registers.
// Stall: while out_stall holds a report, the input register waits, and
// in_stall rises once the input register is also occupied.
// Reset (rst, synchronous): position, phases and reported position clear,
// delta_offset returns to 128, both registers empty.
module quadrature_step_counter_delta_report
  import qscdr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic                       phase_a,
  input  logic                       phase_b,
  input  logic                       report_enable,
  input  logic                       sink_ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [POS_W-1:0]    step_delta,
  output logic signed [OFFSET_W-1:0] offset_delta,
  output logic        [POS_W-1:0]    position,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic        [POS_W-1:0]    cfg_data
);

  logic             s1_valid;
  cmd_t             s1_cmd;
  phase_t           s1_phases;
  logic             s1_enable;
  logic             s1_ready;

  logic [POS_W-1:0] delta_offset;
  logic [POS_W-1:0] step_position;
  logic [POS_W-1:0] step_position_next;
  phase_t           previous_phases;
  phase_t           previous_phases_next;
  logic [POS_W-1:0] reported_position;
  logic [POS_W-1:0] reported_position_next;

  logic             out_free;
  logic             advance;
  logic             emit;
  logic [POS_W-1:0] delta;
  logic [OFFSET_W-1:0] sum;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;

  assign delta = step_position - reported_position;
  assign sum   = {delta[POS_W-1], delta} + {1'b0, delta_offset};

  always_comb begin
    step_position_next     = step_position;
    previous_phases_next   = previous_phases;
    reported_position_next = reported_position;
    emit                   = 1'b0;
    if (advance) begin
      unique case (s1_cmd)
        CMD_PIN: begin
          if (s1_phases == PHASE_10 && previous_phases == PHASE_01) begin
            step_position_next = step_position + 1'b1;
          end else if (s1_phases == PHASE_00 && previous_phases == PHASE_11) begin
            step_position_next = step_position - 1'b1;
          end
          previous_phases_next = s1_phases;
        end
        CMD_TICK: begin
          if (step_position != reported_position) begin
            if (!s1_enable) begin
              reported_position_next = step_position;
            end else if (s1_ready) begin
              emit                   = 1'b1;
              reported_position_next = step_position;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd    <= cmd_t'(cmd);
      s1_phases <= {phase_b, phase_a};
      s1_enable <= report_enable;
      s1_ready  <= sink_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_offset      <= OFFSET_RESET;
      step_position     <= '0;
      previous_phases   <= PHASE_00;
      reported_position <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delta_offset <= cfg_data;
      end
      step_position     <= step_position_next;
      previous_phases   <= previous_phases_next;
      reported_position <= reported_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      step_delta   <= delta;
      offset_delta <= sum;
      position     <= step_position;
    end
  end

endmodule

// File: design/qscdr_checker.sv
// Port-level checker for quadrature_step_counter_delta_report.
// Uses qscdr_pkg for widths; bound to the top level at the end of this file.
module qscdr_checker
  import qscdr_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [POS_W-1:0]    step_delta,
  input logic signed [OFFSET_W-1:0] offset_delta,
  input logic        [POS_W-1:0]    position,
  input logic                       cfg_ready
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("in_stall raised with empty result register");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg_ready dropped");

  a_out_hold: assert property (
    @(posedge clk) disable iff (rst) out_valid && out_stall |=>
      out_valid && $stable(step_delta) && $stable(offset_delta) && $stable(position))
    else $error("stalled transaction changed");

  a_no_zero_delta: assert property (
    @(posedge clk) disable iff (rst) out_valid |-> step_delta != '0)
    else $error("report with zero movement");

endmodule

bind quadrature_step_counter_delta_report qscdr_checker u_qscdr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .step_delta   (step_delta),
  .offset_delta (offset_delta),
  .position     (position),
  .cfg_ready    (cfg_ready)
);

// File: verif/testbench.sv
// Testbench for quadrature_step_counter_delta_report: drives pin samples and report
// ticks, predicts each report from a shadow of the counter state, and checks every report.
// Depends on qscdr_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module testbench;
  import qscdr_pkg::*;

  typedef struct packed {
    cmd_t cmd;
    logic phase_a;
    logic phase_b;
    logic report_en;
    logic sink_rdy;
  } enc_txn_t;

  typedef struct packed {
    logic signed [POS_W-1:0]    delta;
    logic signed [OFFSET_W-1:0] sum;
    logic        [POS_W-1:0]    pos;
  } report_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       cmd = 1'b0;
  logic                       phase_a = 1'b0;
  logic                       phase_b = 1'b0;
  logic                       report_enable = 1'b0;
  logic                       sink_ready = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [POS_W-1:0]    step_delta;
  logic signed [OFFSET_W-1:0] offset_delta;
  logic        [POS_W-1:0]    position;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic        [POS_W-1:0]    cfg_data = '0;

  quadrature_step_counter_delta_report u_top (.*);

  enc_txn_t         txn_q[$];
  report_t          report_q[$];
  logic [POS_W-1:0] step_pos = '0;
  logic [POS_W-1:0] sent_pos = '0;
  phase_t           last_phase = PHASE_00;
  logic [POS_W-1:0] offset_reg = OFFSET_RESET;
  int               send_pct = 0;
  int               recv_pct = 0;
  int               queued_items = 0;
  int               mismatch_count = 0;
  bit               in_taken = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  task automatic advance_encoder(input enc_txn_t t);
    phase_t                  code;
    logic signed [POS_W-1:0] d;
    report_t                 r;
    if (t.cmd == CMD_PIN) begin
      code = {t.phase_b, t.phase_a};
      if (code == PHASE_10 && last_phase == PHASE_01) step_pos = step_pos + 1'b1;
      else if (code == PHASE_00 && last_phase == PHASE_11) step_pos = step_pos - 1'b1;
      last_phase = code;
    end else if (step_pos != sent_pos) begin
      if (!t.report_en) begin
        sent_pos = step_pos;
      end else if (t.sink_rdy) begin
        d = step_pos - sent_pos;
        r.delta = d;
        r.sum = {d[POS_W-1], d} + {1'b0, offset_reg};
        r.pos = step_pos;
        report_q.push_back(r);
        sent_pos = step_pos;
      end
    end
  endtask

  function automatic void push_pin(input phase_t code);
    enc_txn_t t;
    t.cmd = CMD_PIN;
    t.phase_a = code[0];
    t.phase_b = code[1];
    t.report_en = 1'($urandom_range(1));
    t.sink_rdy = 1'($urandom_range(1));
    txn_q.push_back(t);
    queued_items++;
  endfunction

  function automatic void push_tick(input logic en, input logic rdy);
    enc_txn_t t;
    t.cmd = CMD_TICK;
    t.phase_a = 1'($urandom_range(1));
    t.phase_b = 1'($urandom_range(1));
    t.report_en = en;
    t.sink_rdy = rdy;
    txn_q.push_back(t);
    queued_items++;
  endfunction

  function automatic void push_step(input bit up);
    if ($urandom_range(9) == 0) begin
      push_pin(phase_t'($urandom_range(3)));
      push_pin(phase_t'($urandom_range(3)));
    end else if (up) begin
      push_pin(PHASE_01);
      push_pin(PHASE_10);
    end else begin
      push_pin(PHASE_11);
      push_pin(PHASE_00);
    end
  endfunction

  function automatic void queue_random(input int n_items);
    int  target;
    int  len;
    int  r;
    bit  up;
    logic rdy;
    target = queued_items + n_items;
    while (queued_items < target) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_pin(phase_t'($urandom_range(3)));
      end else if (r < 14) begin
        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        up = 1'($urandom_range(1));
        len = ($urandom_range(29) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 6);
        repeat (len) push_step(up);
        rdy = ($urandom_range(3) != 0);
        push_tick(($urandom_range(9) != 0), rdy);
        if (!rdy && $urandom_range(1)) push_tick(1'b1, 1'b1);
      end
    end
  endfunction

  task automatic write_offset(input logic [POS_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    offset_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (txn_q.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  always @(negedge clk) begin : driver
    enc_txn_t t;
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (txn_q.size() != 0 && $urandom_range(99) >= send_pct) begin
          t = txn_q.pop_front();
          in_valid <= 1'b1;
          cmd <= t.cmd;
          phase_a <= t.phase_a;
          phase_b <= t.phase_b;
          report_enable <= t.report_en;
          sink_ready <= t.sink_rdy;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin : monitor
    enc_txn_t t;
    report_t  want;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        t.cmd = cmd_t'(cmd);
        t.phase_a = phase_a;
        t.phase_b = phase_b;
        t.report_en = report_enable;
        t.sink_rdy = sink_ready;
        advance_encoder(t);
      end
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("unexpected report: step_delta %0d offset_delta %0d position %0d",
                 step_delta, offset_delta, position);
          mismatch_count++;
        end else begin
          want = report_q.pop_front();
          if (step_delta !== want.delta) begin
            $error("step_delta: expected %0d, got %0d", want.delta, step_delta);
            mismatch_count++;
          end
          if (offset_delta !== want.sum) begin
            $error("offset_delta: expected %0d, got %0d", want.sum, offset_delta);
            mismatch_count++;
          end
          if (position !== want.pos) begin
            $error("position: expected %0d, got %0d", want.pos, position);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int               send_tab[6];
    int               recv_tab[6];
    logic [POS_W-1:0] offset_tab[6];
    send_tab = '{0, 77, 0, 11, 77, 0};
    recv_tab = '{0, 0, 77, 11, 0, 77};
    offset_tab = '{8'd1, 8'd255, 8'd0, 8'd128, 8'd64, 8'd0};
    offset_tab[5] = 8'($urandom_range(255));
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    push_tick(1'b1, 1'b1);
    push_pin(PHASE_00);
    push_pin(PHASE_01);
    push_pin(PHASE_10);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_pin(PHASE_01);
    push_pin(PHASE_11);
    push_pin(PHASE_00);
    push_pin(PHASE_11);
    push_pin(PHASE_00);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_pin(PHASE_01);
    push_pin(PHASE_10);
    push_pin(PHASE_11);
    push_pin(PHASE_00);
    push_pin(PHASE_11);
    push_pin(PHASE_00);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    drain;

    for (int ph = 0; ph < 6; ph++) begin
      write_offset(offset_tab[ph]);
      send_pct = send_tab[ph];
      recv_pct = recv_tab[ph];
      queue_random(150);
      drain;
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && report_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
